// ===== rtl/core/rdir_pkg.sv =====
// Shared types and constants for the pinhole ray direction core.
`timescale 1ns / 1ps
package rdir_pkg;

  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } rdir_ctl_t;

  localparam int NORM_BITS = 31;
  localparam int SQRT_STEPS = 32;
  localparam int SUM_W = 64;
  localparam int LEN_W = 32;

  localparam logic [2:0] REG_RIGHT = 3'd0;
  localparam logic [2:0] REG_UP = 3'd1;
  localparam logic [2:0] REG_BACK = 3'd2;
  localparam logic [2:0] REG_DIST = 3'd3;
  localparam logic [2:0] REG_SCALE = 3'd4;
  localparam logic [2:0] REG_WIDTH = 3'd5;
  localparam logic [2:0] REG_HEIGHT = 3'd6;

endpackage

// ===== rtl/core/rdir_sqrt_cell.sv =====
// One cell of the square root chain, resolving one bit of the root per stage.
`timescale 1ns / 1ps
module rdir_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  rdir_pkg::rdir_ctl_t              ctl_in,
  input  logic [2:0][rdir_pkg::NORM_BITS-1:0] mag_in,
  input  logic [rdir_pkg::SUM_W-1:0]       n_in,
  input  logic [rdir_pkg::SUM_W-1:0]       res_in,
  output rdir_pkg::rdir_ctl_t              ctl_out,
  output logic [2:0][rdir_pkg::NORM_BITS-1:0] mag_out,
  output logic [rdir_pkg::SUM_W-1:0]       n_out,
  output logic [rdir_pkg::SUM_W-1:0]       res_out
);
  import rdir_pkg::*;

  localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * STEP);

  logic [SUM_W-1:0] trial;
  logic [SUM_W-1:0] n_next;
  logic [SUM_W-1:0] res_next;

  always_comb begin
    trial = res_in + BIT;
    if (n_in >= trial) begin
      n_next = n_in - trial;
      res_next = (res_in >> 1) + BIT;
    end else begin
      n_next = n_in;
      res_next = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_out <= mag_in;
      n_out <= n_next;
      res_out <= res_next;
    end
  end

endmodule

// ===== rtl/core/rdir_div_cell.sv =====
// One cell of the divider chain, producing one quotient bit for each of three lanes.
`timescale 1ns / 1ps
module rdir_div_cell #(
  parameter int QW = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  rdir_pkg::rdir_ctl_t            ctl_in,
  input  logic [rdir_pkg::LEN_W-1:0]     len_in,
  input  logic [2:0][rdir_pkg::LEN_W-1:0] rem_in,
  input  logic [2:0][QW-1:0]             sh_in,
  output rdir_pkg::rdir_ctl_t            ctl_out,
  output logic [rdir_pkg::LEN_W-1:0]     len_out,
  output logic [2:0][rdir_pkg::LEN_W-1:0] rem_out,
  output logic [2:0][QW-1:0]             sh_out
);
  import rdir_pkg::*;

  logic [2:0][LEN_W:0]   r2;
  logic [2:0][LEN_W-1:0] rem_next;
  logic [2:0][QW-1:0]    sh_next;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      r2[l] = {rem_in[l], sh_in[l][QW-1]};
      if (r2[l] >= {1'b0, len_in}) begin
        rem_next[l] = LEN_W'(r2[l] - {1'b0, len_in});
        sh_next[l] = {sh_in[l][QW-2:0], 1'b1};
      end else begin
        rem_next[l] = r2[l][LEN_W-1:0];
        sh_next[l] = {sh_in[l][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_out <= len_in;
      rem_out <= rem_next;
      sh_out <= sh_next;
    end
  end

endmodule

// ===== rtl/core/pinhole_ray_direction_core.sv =====
// Top level of the pinhole camera primary ray direction core.
//
// A request on the slave stream carries a pixel column and row and a
// sub-pixel sample offset. The core answers each request with one unit
// ray direction on the master stream, three signed components with
// FRAC_BITS fraction bits, and tuser set when the direction was zero.
// Camera basis, plane distance, pixel size and plane size are written
// through the cfg port; write them only while no request is in flight,
// which the core does not enforce. The core is fully pipelined and
// takes one request per cycle while s_tready is high. A request passes
// nine arithmetic stages, a chain of 32 square root cells, one setup
// stage, FRAC_BITS + 1 divider cells and one output register.
// When the receiver stalls, a result that cannot leave is parked in a
// skid register and the whole pipeline holds, so s_tready drops at the
// edge where a second result reaches the stalled output and rises again
// at the edge where the parked result moves to the output register.
// Reset empties the pipeline and loads the default camera: identity
// basis, distance 100, pixel size 1, 640 x 480.
`timescale 1ns / 1ps
module pinhole_ray_direction_core #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS = 14,
  localparam int IN_W = ((2 * COORD_BITS + 16 + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,   // pixel_col, pixel_row, sub_x, sub_y
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [47:0]     m_tdata,   // dir_x, dir_y, dir_z
  output logic            m_tuser,   // degenerate
  input  logic            cfg_wen,
  input  logic [2:0]      cfg_index,
  input  logic [47:0]     cfg_data
);
  import rdir_pkg::*;

  localparam int C = COORD_BITS;
  localparam int PW = ((C + 8 > 20) ? C + 8 : 20) + 2;
  localparam int PXW = PW + 17;
  localparam int PRW = PXW + 16;
  localparam int DW = PRW + 2;
  localparam int SHW = $clog2(DW + 1);
  localparam int QW = FRAC_BITS + 1;
  localparam int NW = NORM_BITS + FRAC_BITS + 1;
  localparam int VW = (QW + 1 > 16) ? QW + 1 : 16;
  localparam logic [QW-1:0] UNIT = QW'(1) << FRAC_BITS;

  logic [47:0] basis_right;
  logic [47:0] basis_up;
  logic [47:0] basis_back;
  logic [15:0] plane_distance;
  logic [15:0] pixel_scale;
  logic [12:0] plane_width;
  logic [12:0] plane_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_right <= 48'h4000_0000_0000;
      basis_up <= 48'h0000_4000_0000;
      basis_back <= 48'h0000_0000_4000;
      plane_distance <= 16'd25600;
      pixel_scale <= 16'd4096;
      plane_width <= 13'd640;
      plane_height <= 13'd480;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_RIGHT:  basis_right <= cfg_data;
        REG_UP:     basis_up <= cfg_data;
        REG_BACK:   basis_back <= cfg_data;
        REG_DIST:   plane_distance <= cfg_data[15:0];
        REG_SCALE:  pixel_scale <= cfg_data[15:0];
        REG_WIDTH:  plane_width <= cfg_data[12:0];
        REG_HEIGHT: plane_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_valid;
  assign en = !skid_valid;
  assign s_tready = en;

  logic [8:0] v;
  rdir_ctl_t sq_ctl_in;
  rdir_ctl_t div_ctl_in;
  rdir_ctl_t out_ctl;

  logic signed [PW-1:0]  pcx, pcy;
  logic signed [PXW-1:0] px, py;
  logic signed [29:0]    dist_shifted;
  logic signed [2:0][PRW-1:0] pu, pv, pw;
  logic signed [2:0][DW-1:0]  d;
  logic [2:0][DW-1:0] mg5, mg6;
  logic [2:0] ng5, ng6, ng7, ng8, ng9;
  logic dg6, dg7, dg8, dg9;
  logic [DW-1:0] big;
  logic [SHW-1:0] shift;
  logic [2:0][NORM_BITS-1:0] m7, m8, m9;
  logic [2:0][2*NORM_BITS-1:0] sq;
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:0], s_tvalid};
    end
  end

  always_comb begin
    big = mg5[0];
    if (mg5[1] > big) big = mg5[1];
    if (mg5[2] > big) big = mg5[2];
  end

  logic [SHW-1:0] blen;
  always_comb begin
    blen = '0;
    for (int i = 0; i < DW; i++) begin
      if (big[i]) blen = SHW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcx <= $signed(PW'({s_tdata[C-1:0], 8'd0})) - $signed(PW'({plane_width, 7'd0}))
             + $signed(PW'(s_tdata[2*C+7:2*C]));
      pcy <= $signed(PW'({s_tdata[2*C-1:C], 8'd0})) - $signed(PW'({plane_height, 7'd0}))
             + $signed(PW'(s_tdata[2*C+15:2*C+8]));
      px <= PXW'(pcx * $signed({1'b0, pixel_scale}));
      py <= PXW'(pcy * $signed({1'b0, pixel_scale}));
      dist_shifted <= $signed({2'b00, plane_distance, 12'd0});
      for (int l = 0; l < 3; l++) begin
        pu[l] <= PRW'($signed(basis_right[32-16*l +: 16]) * px);
        pv[l] <= PRW'($signed(basis_up[32-16*l +: 16]) * py);
        pw[l] <= PRW'($signed(basis_back[32-16*l +: 16]) * dist_shifted);
        d[l] <= DW'($signed(pu[l])) + DW'($signed(pv[l])) - DW'($signed(pw[l]));
        mg5[l] <= d[l][DW-1] ? DW'(-d[l]) : d[l];
        ng5[l] <= d[l][DW-1];
        m7[l] <= NORM_BITS'(mg6[l] >> shift);
        sq[l] <= m7[l] * m7[l];
      end
      mg6 <= mg5;
      ng6 <= ng5;
      dg6 <= (big == '0);
      shift <= (blen > SHW'(NORM_BITS)) ? SHW'(blen - SHW'(NORM_BITS)) : '0;
      ng7 <= ng6;
      dg7 <= dg6;
      m8 <= m7;
      ng8 <= ng7;
      dg8 <= dg7;
      m9 <= m8;
      ng9 <= ng8;
      dg9 <= dg8;
      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end
  end

  assign sq_ctl_in = '{valid: v[8], degen: dg9, neg: ng9};

  rdir_ctl_t                 sc_ctl [0:SQRT_STEPS];
  logic [2:0][NORM_BITS-1:0] sc_mag [0:SQRT_STEPS];
  logic [SUM_W-1:0]          sc_n   [0:SQRT_STEPS];
  logic [SUM_W-1:0]          sc_res [0:SQRT_STEPS];

  assign sc_ctl[0] = sq_ctl_in;
  assign sc_mag[0] = m9;
  assign sc_n[0] = sum;
  assign sc_res[0] = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    rdir_sqrt_cell #(.STEP(SQRT_STEPS - 1 - i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(sc_ctl[i]), .mag_in(sc_mag[i]), .n_in(sc_n[i]), .res_in(sc_res[i]),
      .ctl_out(sc_ctl[i+1]), .mag_out(sc_mag[i+1]), .n_out(sc_n[i+1]),
      .res_out(sc_res[i+1])
    );
  end

  logic [LEN_W-1:0] len_c;
  logic [2:0][NW-1:0] num_c;
  logic [LEN_W-1:0] dv_len0;
  logic [2:0][LEN_W-1:0] dv_rem0;
  logic [2:0][QW-1:0] dv_sh0;

  always_comb begin
    len_c = sc_res[SQRT_STEPS][LEN_W-1:0];
    if (len_c == '0) len_c = LEN_W'(1);
    for (int l = 0; l < 3; l++) begin
      num_c[l] = {sc_mag[SQRT_STEPS][l], FRAC_BITS'(0)} + NW'(len_c >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_ctl_in <= '0;
    end else if (en) begin
      div_ctl_in <= sc_ctl[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_len0 <= len_c;
      for (int l = 0; l < 3; l++) begin
        dv_rem0[l] <= LEN_W'(num_c[l][NW-1:QW]);
        dv_sh0[l] <= num_c[l][QW-1:0];
      end
    end
  end

  rdir_ctl_t             dc_ctl [0:QW];
  logic [LEN_W-1:0]      dc_len [0:QW];
  logic [2:0][LEN_W-1:0] dc_rem [0:QW];
  logic [2:0][QW-1:0]    dc_sh  [0:QW];

  assign dc_ctl[0] = div_ctl_in;
  assign dc_len[0] = dv_len0;
  assign dc_rem[0] = dv_rem0;
  assign dc_sh[0] = dv_sh0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    rdir_div_cell #(.QW(QW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(dc_ctl[i]), .len_in(dc_len[i]), .rem_in(dc_rem[i]), .sh_in(dc_sh[i]),
      .ctl_out(dc_ctl[i+1]), .len_out(dc_len[i+1]), .rem_out(dc_rem[i+1]),
      .sh_out(dc_sh[i+1])
    );
  end

  assign out_ctl = dc_ctl[QW];

  logic [47:0] res_data;
  logic [QW-1:0] qs;
  logic signed [VW-1:0] qv;

  always_comb begin
    res_data = '0;
    for (int l = 0; l < 3; l++) begin
      qs = (dc_sh[QW][l] > UNIT) ? UNIT : dc_sh[QW][l];
      qv = $signed(VW'(qs));
      if (out_ctl.neg[l]) qv = -qv;
      if (!out_ctl.degen) res_data[16*l +: 16] = qv[15:0];
    end
  end

  logic [47:0] skid_data;
  logic        skid_user;
  logic        pipe_out;

  assign pipe_out = out_ctl.valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= skid_valid || pipe_out;
        skid_valid <= 1'b0;
      end else if (pipe_out) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= res_data;
        m_tuser <= out_ctl.degen;
      end
    end else if (pipe_out) begin
      skid_data <= res_data;
      skid_user <= out_ctl.degen;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid holds data while output is empty");
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tvalid && !m_tready) |=> skid_valid)
    else $error("parked result lost during stall");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("zero direction result carries nonzero data");
  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> $stable(m_tdata))
    else $error("output changed while receiver stalled");

endmodule
